>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers included by the decoder unit. Each macro expects signals named
// clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, switched off while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every rising clock edge, switched off while in reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types and constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

  localparam int unsigned CpW = 21;

  typedef logic [7:0]     byte_t;
  typedef logic [CpW-1:0] cp_t;
  typedef logic [1:0]     pend_t;

  // Largest Unicode scalar value.
  localparam cp_t CP_MAX = 21'h10FFFF;

  // Lead byte ranges.
  localparam byte_t LEAD2_LO = 8'hC2;
  localparam byte_t LEAD2_HI = 8'hDF;
  localparam byte_t LEAD3_LO = 8'hE0;
  localparam byte_t LEAD3_HI = 8'hEF;
  localparam byte_t LEAD4_LO = 8'hF0;
  localparam byte_t LEAD4_HI = 8'hF4;

  // Continuation bytes still expected after each lead byte kind.
  localparam pend_t PEND_NONE = 2'd0;
  localparam pend_t PEND_ONE  = 2'd1;
  localparam pend_t PEND_TWO  = 2'd2;
  localparam pend_t PEND_THR  = 2'd3;

endpackage

`default_nettype wire

>>> src/u8dec_byte_if.sv
// ----------------------------------------------------------------------------
// u8dec_byte_if
// Valid/ready channel that carries one raw source byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8dec_byte_if;
  import u8dec_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> src/u8dec_cp_if.sv
// ----------------------------------------------------------------------------
// u8dec_cp_if
// Valid/ready channel that carries one decoded code point per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8dec_cp_if;
  import u8dec_pkg::*;

  logic valid;
  logic ready;
  cp_t  code_point;
  logic end_flag;

  modport source (output valid, output code_point, output end_flag, input ready);
  modport sink   (input valid, input code_point, input end_flag, output ready);
endinterface

`default_nettype wire

>>> src/utf8_codepoint_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit
// Decodes UTF-8 into Unicode code points, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// The decoder takes one byte per transfer on in_if and gives at most one code
// point per byte on out_if, so it sustains one byte every clock cycle while
// the result side keeps taking transfers. A byte passes through two registers:
// the byte register, and the result register that holds the decoded value.
// The decode decision itself is a small piece of logic on the byte register,
// the 2-bit count of continuation bytes still expected and the 21-bit partial
// value. Lead bytes C2-DF, E0-EF and F0-F4 open sequences of 2, 3 and 4
// bytes; ASCII bytes come out unchanged; a zero byte gives code point 0 with
// end_flag set and clears any open sequence. Stray continuation bytes, the
// bytes C0, C1 and F5-FF, and finished values above 10FFFF give no result. A
// byte that is not a continuation byte arriving mid-sequence abandons the
// sequence and is then decoded afresh. Overlong three- and four-byte forms
// and surrogates are passed through. When the byte register holds a byte
// while the result register is full and not being emptied, that byte stays
// where it is, even if it will give no result, and in_if.ready falls in the
// same cycle; an empty byte register still takes a new byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  u8dec_byte_if.sink          in_if,
  u8dec_cp_if.source          out_if
);
  import u8dec_pkg::*;

  // Byte register stage.
  logic  s1_valid_r;
  byte_t s1_byte_r;

  // Decoder state.
  pend_t pend_r, pend_nxt;
  cp_t   part_r, part_nxt;

  // Result register.
  logic  out_valid_r;
  cp_t   out_cp_r;
  logic  out_end_r;

  // Decode outputs for the byte in the byte register.
  logic  emit;
  cp_t   cp_nxt;
  logic  end_nxt;
  cp_t   shifted;
  logic  cont;

  // The result register can take a new value when it is empty or its current
  // value is being transferred out this cycle.
  logic  out_free;
  logic  s1_adv;

  assign out_free = !out_valid_r || out_if.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;

  assign out_if.valid      = out_valid_r;
  assign out_if.code_point = out_cp_r;
  assign out_if.end_flag   = out_end_r;

  // Continuation bytes are 10xxxxxx.
  assign cont    = (s1_byte_r[7:6] == 2'b10);
  assign shifted = {part_r[CpW-7:0], s1_byte_r[5:0]};

  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    emit     = 1'b0;
    cp_nxt   = '0;
    end_nxt  = 1'b0;
    if ((pend_r != PEND_NONE) && cont) begin
      // Fold six more bits into the open sequence.
      pend_nxt = pend_r - PEND_ONE;
      if (pend_r == PEND_ONE) begin
        part_nxt = '0;
        cp_nxt   = shifted;
        emit     = (shifted <= CP_MAX);
      end else begin
        part_nxt = shifted;
      end
    end else begin
      // Any open sequence is abandoned and the byte is taken as a fresh one.
      pend_nxt = PEND_NONE;
      part_nxt = '0;
      if (s1_byte_r == 8'h00) begin
        emit    = 1'b1;
        end_nxt = 1'b1;
      end else if (!s1_byte_r[7]) begin
        emit   = 1'b1;
        cp_nxt = {{(CpW-8){1'b0}}, s1_byte_r};
      end else if ((s1_byte_r >= LEAD2_LO) && (s1_byte_r <= LEAD2_HI)) begin
        pend_nxt = PEND_ONE;
        part_nxt = {{(CpW-5){1'b0}}, s1_byte_r[4:0]};
      end else if ((s1_byte_r >= LEAD3_LO) && (s1_byte_r <= LEAD3_HI)) begin
        pend_nxt = PEND_TWO;
        part_nxt = {{(CpW-4){1'b0}}, s1_byte_r[3:0]};
      end else if ((s1_byte_r >= LEAD4_LO) && (s1_byte_r <= LEAD4_HI)) begin
        pend_nxt = PEND_THR;
        part_nxt = {{(CpW-3){1'b0}}, s1_byte_r[2:0]};
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= PEND_NONE;
      part_r      <= '0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r && emit;
      end
      if (s1_adv) begin
        pend_r <= pend_nxt;
        part_r <= part_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_byte_r <= in_if.in_byte;
    end
    if (s1_adv && emit) begin
      out_cp_r  <= cp_nxt;
      out_end_r <= end_nxt;
    end
  end

`include "assert_macros.svh"

  // With no sequence open the partial value has been cleared.
  `ASSERT_IMP(a_idle_part_zero, pend_r == PEND_NONE, part_r == '0, "partial value left over")
  // After a four-byte lead only its three value bits are held.
  `ASSERT_IMP(a_lead4_narrow, pend_r == PEND_THR, part_r[CpW-1:3] == '0, "lead value too wide")
  // A held result is never above the Unicode range.
  `ASSERT_IMP(a_out_in_range, out_valid_r, out_cp_r <= CP_MAX, "code point out of range")
  // The end-of-source result always carries code point zero.
  `ASSERT_IMP(a_end_zero, out_valid_r && out_end_r, out_cp_r == '0, "end result not zero")

endmodule

`default_nettype wire
